// ===== design/cmf_pkg.sv =====
`default_nettype none

package cmf_pkg;

	// field widths
	localparam int OP_W     = 2;
	localparam int ID_W     = 29;
	localparam int DATA_W   = 64;
	localparam int TIME_W   = 32;
	localparam int STATUS_W = 3;

	localparam int DEPTH_DEFAULT = 64;

	// operation codes, pop is any code with the upper bit set
	localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
	localparam logic [OP_W-1:0] OP_REPLACE = 2'd1;
	localparam logic [OP_W-1:0] OP_POP     = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_POPPED   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic pop_read;
		logic scan_step;
		logic commit;
	} cmf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_more;
		logic scan_pending;
		logic hit_now;
		logic out_free;
	} cmf_stat_t;

endpackage

`default_nettype wire

// ===== design/cmf_ctrl.sv =====
`default_nettype none

module cmf_ctrl import cmf_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic [OP_W-1:0] operation,
	input  wire cmf_stat_t       stat,
	output logic                 in_ready,
	output cmf_cmd_t             cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_POP_RD = 2'd1;
	localparam logic [1:0] S_SCAN   = 2'd2;
	localparam logic [1:0] S_DONE   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (operation[1])
						state_nxt = S_POP_RD;
					else if (operation == OP_REPLACE)
						state_nxt = S_SCAN;
					else
						state_nxt = S_DONE;
				end
			end
			S_POP_RD: begin
				cmd.pop_read = 1'b1;
				state_nxt    = S_DONE;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				// stop on first match or once every issued read is compared
				if (stat.hit_now || (!stat.scan_more && !stat.scan_pending))
					state_nxt = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nxt;
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

`default_nettype wire

// ===== design/cmf_datapath.sv =====
`default_nettype none

module cmf_datapath import cmf_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [OP_W-1:0]     operation,
	input  wire logic [ID_W-1:0]     msg_id,
	input  wire logic [DATA_W-1:0]   payload,
	input  wire logic [TIME_W-1:0]   timestamp,
	input  wire cmf_cmd_t            cmd,
	input  wire logic                out_ready,
	output cmf_stat_t                stat,
	output logic                     out_valid,
	output logic [STATUS_W-1:0]      status,
	output logic [ID_W-1:0]          out_id,
	output logic [DATA_W-1:0]        out_payload,
	output logic [TIME_W-1:0]        out_timestamp,
	output logic [CW-1:0]            fill_count
);

	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	// entry storage
	logic [ID_W-1:0]   mem_id   [DEPTH];
	logic [DATA_W-1:0] mem_data [DEPTH];
	logic [TIME_W-1:0] mem_time [DEPTH];

	// ring pointers and occupancy
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] count_q;

	// latched transaction
	logic [OP_W-1:0]   op_q;
	logic [ID_W-1:0]   id_q;
	logic [DATA_W-1:0] data_q;
	logic [TIME_W-1:0] time_q;

	// scan
	logic [AW-1:0] scan_idx_q;
	logic [CW-1:0] scan_cnt_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;
	logic          hit_q;
	logic [AW-1:0] hit_idx_q;

	// registered read data
	logic [ID_W-1:0]   id_rd_s1;
	logic [DATA_W-1:0] data_rd_s1;
	logic [TIME_W-1:0] time_rd_s1;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_id_en;
	logic          wr_body_en;
	logic [AW-1:0] wr_addr;

	logic          is_pop;
	logic          is_replace;
	logic          empty;
	logic          full;

	assign is_pop     = op_q[1];
	assign is_replace = (op_q == OP_REPLACE);
	assign empty      = (count_q == '0);
	assign full       = (count_q == FULL_CNT);

	assign stat.scan_more    = (scan_cnt_q < count_q);
	assign stat.scan_pending = rd_vld_s1;
	assign stat.hit_now      = rd_vld_s1 && (id_rd_s1 == id_q);
	assign stat.out_free     = !out_valid || out_ready;

	always_comb begin
		rd_en   = cmd.pop_read || (cmd.scan_step && stat.scan_more);
		rd_addr = cmd.pop_read ? head_q : scan_idx_q;
	end

	// commit write: a replace that hits touches payload and time only
	always_comb begin
		wr_id_en   = 1'b0;
		wr_body_en = 1'b0;
		wr_addr    = tail_q;
		if (cmd.commit && !is_pop) begin
			if (is_replace && hit_q) begin
				wr_body_en = 1'b1;
				wr_addr    = hit_idx_q;
			end else if (!full) begin
				wr_id_en   = 1'b1;
				wr_body_en = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_id_en)
			mem_id[wr_addr] <= id_q;
		if (wr_body_en) begin
			mem_data[wr_addr] <= data_q;
			mem_time[wr_addr] <= time_q;
		end
		if (rd_en) begin
			id_rd_s1   <= mem_id[rd_addr];
			data_rd_s1 <= mem_data[rd_addr];
			time_rd_s1 <= mem_time[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			id_q   <= msg_id;
			data_q <= payload;
			time_q <= timestamp;
		end
		rd_idx_s1 <= scan_idx_q;
		if (cmd.scan_step && stat.hit_now)
			hit_idx_q <= rd_idx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			scan_idx_q <= '0;
			scan_cnt_q <= '0;
			rd_vld_s1  <= 1'b0;
			hit_q      <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_step && stat.scan_more;
			if (cmd.load) begin
				scan_idx_q <= head_q;
				scan_cnt_q <= '0;
				hit_q      <= 1'b0;
			end else if (cmd.scan_step && stat.scan_more) begin
				scan_idx_q <= next_idx(scan_idx_q);
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			if (cmd.scan_step && stat.hit_now)
				hit_q <= 1'b1;
			if (cmd.commit) begin
				if (is_pop) begin
					if (!empty) begin
						head_q  <= next_idx(head_q);
						count_q <= count_q - 1'b1;
					end
				end else if (!(is_replace && hit_q) && !full) begin
					tail_q  <= next_idx(tail_q);
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (cmd.commit)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_id        <= '0;
			out_payload   <= '0;
			out_timestamp <= '0;
			if (is_pop) begin
				if (empty) begin
					status     <= ST_EMPTY;
					fill_count <= count_q;
				end else begin
					status        <= ST_POPPED;
					out_id        <= id_rd_s1;
					out_payload   <= data_rd_s1;
					out_timestamp <= time_rd_s1;
					fill_count    <= count_q - 1'b1;
				end
			end else if (is_replace && hit_q) begin
				status     <= ST_REPLACED;
				fill_count <= count_q;
			end else if (full) begin
				status     <= ST_DROPPED;
				fill_count <= count_q;
			end else begin
				status     <= ST_APPENDED;
				fill_count <= count_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/coalescing_can_message_fifo.sv =====
`default_nettype none

// ring fifo of can frames with push, add-or-replace by identifier and pop.
// one transaction is in work at a time; each gives exactly one result
// transaction. a push goes straight to its commit, and a pop first makes one
// registered read of the head entry. an add-or-replace reads the identifier
// store oldest first, one entry per cycle, through its single registered read
// port, and stops on the first match or once every issued read is compared;
// the slowest case is a miss in a full 64-entry fifo. the input is taken
// again once the result sits in the output register, so a waiting result
// does not block the next transaction until its commit. storage is not
// cleared at reset; only occupied entries are ever compared or returned.

module coalescing_can_message_fifo import cmf_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [OP_W-1:0]     operation,
	input  wire logic [ID_W-1:0]     msg_id,
	input  wire logic [DATA_W-1:0]   payload,
	input  wire logic [TIME_W-1:0]   timestamp,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [STATUS_W-1:0]      status,
	output logic [ID_W-1:0]          out_id,
	output logic [DATA_W-1:0]        out_payload,
	output logic [TIME_W-1:0]        out_timestamp,
	output logic [CW-1:0]            fill_count
);

	// command and status between sequencer and datapath
	cmf_cmd_t  cmd;
	cmf_stat_t stat;

	// sequencer: idle, head read for pop, identifier scan, commit
	cmf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.stat      (stat),
		.in_ready  (in_ready),
		.cmd       (cmd)
	);

	// storage, ring pointers, scan pipeline and output register
	cmf_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.operation     (operation),
		.msg_id        (msg_id),
		.payload       (payload),
		.timestamp     (timestamp),
		.cmd           (cmd),
		.out_ready     (out_ready),
		.stat          (stat),
		.out_valid     (out_valid),
		.status        (status),
		.out_id        (out_id),
		.out_payload   (out_payload),
		.out_timestamp (out_timestamp),
		.fill_count    (fill_count)
	);

	// a transaction taken leaves the sequencer busy straight after acceptance
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken again straight after acceptance");

	// a commit always leaves a result in the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("commit without a result");

	// only a popped frame carries frame fields
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_POPPED) |->
		(out_id == '0 && out_payload == '0 && out_timestamp == '0))
		else $error("frame fields set on a non-pop result");

	// an append or a replace leaves the fifo occupied
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_APPENDED || status == ST_REPLACED)) |->
		(fill_count != '0))
		else $error("append or replace with empty fifo");

endmodule

`default_nettype wire

// ===== bench/coalescing_can_message_fifo_tb.sv =====
import cmf_pkg::*;

typedef struct packed {
	logic [STATUS_W-1:0]                  status;
	logic [ID_W-1:0]                      ident;
	logic [DATA_W-1:0]                    data;
	logic [TIME_W-1:0]                    stamp;
	logic [$clog2(DEPTH_DEFAULT + 1)-1:0] fill;
} can_result_t;

class frame_fifo_scoreboard;
	localparam int SLOTS = DEPTH_DEFAULT;
	localparam int FILL_BITS = $clog2(SLOTS + 1);

	logic [ID_W-1:0]   slot_ident [SLOTS];
	logic [DATA_W-1:0] slot_bytes [SLOTS];
	logic [TIME_W-1:0] slot_stamp [SLOTS];
	int unsigned       head;
	int unsigned       tail;
	int unsigned       occupancy;
	can_result_t       pending_results [$];
	int unsigned       errors;

	function new();
		head = 0;
		tail = 0;
		occupancy = 0;
		errors = 0;
	endfunction

	function int unsigned outstanding();
		return pending_results.size();
	endfunction

	function logic [STATUS_W-1:0] append_frame(logic [ID_W-1:0] id, logic [DATA_W-1:0] data,
			logic [TIME_W-1:0] stamp);
		if (occupancy >= SLOTS)
			return ST_DROPPED;
		slot_ident[tail] = id;
		slot_bytes[tail] = data;
		slot_stamp[tail] = stamp;
		tail = (tail + 1) % SLOTS;
		occupancy++;
		return ST_APPENDED;
	endfunction

	// work out the result of one accepted request and queue it
	task accept_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
			input logic [DATA_W-1:0] data, input logic [TIME_W-1:0] stamp);
		can_result_t r;
		int unsigned slot;
		int unsigned k;
		bit hit;
		r = '0;
		hit = 1'b0;
		if (op[1]) begin
			if (occupancy == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.ident = slot_ident[head];
				r.data = slot_bytes[head];
				r.stamp = slot_stamp[head];
				slot_ident[head] = '0;
				slot_bytes[head] = '0;
				head = (head + 1) % SLOTS;
				occupancy--;
				r.status = ST_POPPED;
			end
		end else if (op == OP_REPLACE) begin
			slot = head;
			for (k = 0; k < occupancy && !hit; k++) begin
				if (slot_ident[slot] == id) begin
					slot_bytes[slot] = data;
					slot_stamp[slot] = stamp;
					hit = 1'b1;
				end else begin
					slot = (slot + 1) % SLOTS;
				end
			end
			r.status = hit ? ST_REPLACED : append_frame(id, data, stamp);
		end else begin
			r.status = append_frame(id, data, stamp);
		end
		r.fill = FILL_BITS'(occupancy);
		pending_results.push_back(r);
	endtask

	task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("mismatch %0d at %0t: %s got %h expected %h", errors, $time, what, got,
			want);
	endtask

	task check_response(input can_result_t got);
		can_result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("unexpected result, status", 64'(got.status), '0);
		end else begin
			want = pending_results.pop_front();
			if (got.status !== want.status)
				report_mismatch("status", 64'(got.status), 64'(want.status));
			if (got.ident !== want.ident)
				report_mismatch("out_id", 64'(got.ident), 64'(want.ident));
			if (got.data !== want.data)
				report_mismatch("out_payload", got.data, want.data);
			if (got.stamp !== want.stamp)
				report_mismatch("out_timestamp", 64'(got.stamp), 64'(want.stamp));
			if (got.fill !== want.fill)
				report_mismatch("fill_count", 64'(got.fill), 64'(want.fill));
		end
	endtask
endclass

module coalescing_can_message_fifo_tb;
	import cmf_pkg::*;

	// upper operation bit alone selects a pop, so the spare code pops too
	localparam logic [OP_W-1:0] OP_POP_ALIAS = 2'd3;
	localparam int FILL_W = $clog2(DEPTH_DEFAULT + 1);

	localparam int RANDOM_ITEMS = 1070;
	localparam int CALM_ITEMS   = 150;      // closing stretch with no idling
	localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
	localparam int HOLD_AFTER   = 500;      // transactions before the hold-off
	localparam int SETTLE_CYCLES = 100;     // longest scan plus margin
	localparam int RECENT_MAX   = 80;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [OP_W-1:0]     operation;
	logic [ID_W-1:0]     msg_id;
	logic [DATA_W-1:0]   payload;
	logic [TIME_W-1:0]   timestamp;
	logic                out_valid;
	logic                out_ready;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     out_id;
	logic [DATA_W-1:0]   out_payload;
	logic [TIME_W-1:0]   out_timestamp;
	logic [FILL_W-1:0]   fill_count;

	frame_fifo_scoreboard frame_board = new();

	// sender and receiver state; calm and hold_request are shared by both
	bit          calm = 1'b0;
	bit          hold_request = 1'b0;
	bit          sender_gaps = 1'b1;
	int unsigned items_sent = 0;

	// identifiers already sent, so that add-or-replace finds matches
	logic [ID_W-1:0] recent_ids [$];
	logic [ID_W-1:0] hot_ids [4];

	coalescing_can_message_fifo dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.msg_id(msg_id),
		.payload(payload),
		.timestamp(timestamp),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.out_id(out_id),
		.out_payload(out_payload),
		.out_timestamp(out_timestamp),
		.fill_count(fill_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// both channels sampled on the edge, before any driven change lands
	always @(posedge clk) begin : monitor
		can_result_t seen;
		if (arst_n) begin
			if (in_valid && in_ready)
				frame_board.accept_request(operation, msg_id, payload, timestamp);
			if (out_valid && out_ready) begin
				seen.status = status;
				seen.ident = out_id;
				seen.data = out_payload;
				seen.stamp = out_timestamp;
				seen.fill = fill_count;
				frame_board.check_response(seen);
			end
		end
	end

	// present one transaction and hold it until the block takes it
	task automatic send_frame(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
			input logic [DATA_W-1:0] data, input logic [TIME_W-1:0] stamp);
		in_valid <= 1'b1;
		operation <= op;
		msg_id <= id;
		payload <= data;
		timestamp <= stamp;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
		// occasional idle burst, never while the receiver is holding off
		if (!calm && !hold_request && sender_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	function automatic logic [ID_W-1:0] pick_ident();
		logic [ID_W-1:0] id;
		case ($urandom_range(0, 5))
			0, 1: id = recent_ids.size() != 0 ?
				recent_ids[$urandom_range(0, recent_ids.size() - 1)] : hot_ids[0];
			2: id = hot_ids[$urandom_range(0, 3)];
			default: id = ID_W'($urandom());
		endcase
		return id;
	endfunction

	function automatic logic [OP_W-1:0] pick_op();
		logic [OP_W-1:0] op;
		case ($urandom_range(0, 9))
			0, 1, 2: op = OP_PUSH;
			3, 4, 5: op = OP_REPLACE;
			6, 7: op = OP_POP;
			default: op = OP_POP_ALIAS;
		endcase
		return op;
	endfunction

	task automatic send_random(input logic [OP_W-1:0] op);
		logic [ID_W-1:0] id;
		id = pick_ident();
		if (!op[1]) begin
			recent_ids.push_back(id);
			if (recent_ids.size() > RECENT_MAX)
				void'(recent_ids.pop_front());
		end
		send_frame(op, id, {$urandom(), $urandom()}, $urandom());
	endtask

	// push a run near the depth, then a few more so that drops and full-fifo hits occur
	task automatic fill_burst();
		repeat ($urandom_range(60, 72))
			send_random(($urandom_range(0, 3) == 0) ? OP_REPLACE : OP_PUSH);
		repeat ($urandom_range(4, 10))
			send_random(($urandom_range(0, 1) == 0) ? OP_REPLACE : OP_PUSH);
	endtask

	// pop, often past empty
	task automatic drain_burst();
		repeat ($urandom_range(1, 70))
			send_random(($urandom_range(0, 1) == 0) ? OP_POP : OP_POP_ALIAS);
	endtask

	task automatic mixed_burst();
		repeat ($urandom_range(10, 30))
			send_random(pick_op());
	endtask

	task automatic random_burst();
		sender_gaps = ($urandom_range(0, 2) != 0);
		case ($urandom_range(0, 9))
			0, 1, 2: fill_burst();
			3, 4, 5: drain_burst();
			default: mixed_burst();
		endcase
	endtask

	// receiver: random stall bursts in stretches, the one long hold-off, none at the end
	initial begin : receiver
		int stretch_left;
		bit stalls_on;
		stretch_left = 0;
		stalls_on = 1'b1;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (stretch_left <= 0) begin
				stretch_left = $urandom_range(20, 80);
				stalls_on = ($urandom_range(0, 2) != 0);
			end
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else if (!calm && stalls_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
			stretch_left--;
		end
	end

	initial begin : stimulus
		bit hold_used;
		hold_used = 1'b0;
		foreach (hot_ids[i])
			hot_ids[i] = ID_W'($urandom());
		arst_n = 1'b0;
		in_valid <= 1'b0;
		operation <= OP_PUSH;
		msg_id <= '0;
		payload <= '0;
		timestamp <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pop from an empty fifo, with both pop codes
		send_frame(OP_POP, 29'h1FFF_FFFF, '1, '1);
		send_frame(OP_POP_ALIAS, '0, '0, '0);
		// field extremes
		send_frame(OP_PUSH, 29'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send_frame(OP_PUSH, 29'h0000_0000, 64'h0, 32'h0);
		// match on the oldest entry, updated in place
		send_frame(OP_REPLACE, 29'h1FFF_FFFF, 64'h0123_4567_89AB_CDEF, 32'h0000_0001);
		// identifiers differing only in the lowest or highest bit miss and append
		send_frame(OP_REPLACE, 29'h1FFF_FFFE, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
		send_frame(OP_REPLACE, 29'h0FFF_FFFF, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
		// match on a zero identifier
		send_frame(OP_REPLACE, 29'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000);
		// duplicate identifier, then replace must hit the older copy only
		send_frame(OP_PUSH, 29'h1FFF_FFFE, 64'h8000_0000_0000_0001, 32'h7FFF_FFFF);
		send_frame(OP_REPLACE, 29'h1FFF_FFFE, 64'hFEDC_BA98_7654_3210, 32'h0000_0002);
		// drain all of it, both pop codes, and one past empty
		send_frame(OP_POP, '0, '0, '0);
		send_frame(OP_POP_ALIAS, '0, '0, '0);
		send_frame(OP_POP, '0, '0, '0);
		send_frame(OP_POP_ALIAS, '0, '0, '0);
		send_frame(OP_POP, '0, '0, '0);
		send_frame(OP_POP, '0, '0, '0);
		// reuse of freed slots after the fifo has drained
		send_frame(OP_PUSH, 29'h0AAA_AAAA, 64'h0F0F_0F0F_0F0F_0F0F, 32'h1234_5678);
		send_frame(OP_REPLACE, 29'h1555_5555, 64'hF0F0_F0F0_F0F0_F0F0, 32'h8765_4321);
		send_frame(OP_POP, '0, '0, '0);

		while (items_sent < RANDOM_ITEMS) begin
			// the receiver stops for a long while; keep offering so the input stalls
			if (!hold_used && items_sent > HOLD_AFTER) begin
				hold_used = 1'b1;
				hold_request = 1'b1;
				while (hold_request)
					send_random(pick_op());
			end
			random_burst();
		end

		// closing stretch with both sides running flat out
		calm = 1'b1;
		while (items_sent < RANDOM_ITEMS + CALM_ITEMS)
			random_burst();
		in_valid <= 1'b0;

		while (frame_board.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (frame_board.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#5000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/cmf_pkg.sv
design/cmf_ctrl.sv
design/cmf_datapath.sv
design/coalescing_can_message_fifo.sv
bench/coalescing_can_message_fifo_tb.sv
